// ===== src/ssi_pkg.sv =====
// shared widths and types for the segment / sphere intersection pipeline
`default_nettype none
package ssi_pkg;

  localparam int CW   = 32;            // coordinate width
  localparam int DW   = CW + 1;        // coordinate difference width
  localparam int PW   = 2 * DW + 2;    // width of a, b, c
  localparam int MW   = PW - 1;        // magnitude width of a, b, c
  localparam int LW   = (MW + 1) / 2;  // low partial product slice
  localparam int UW   = MW - LW;       // high partial product slice
  localparam int QW   = 2 * PW;        // discriminant width
  localparam int RW   = QW / 2;        // square root width, one bit per stage
  localparam int NW   = PW + 1;        // numerator width
  localparam int HW   = (NW + 1) / 2;  // low slice of numerator magnitude
  localparam int NHW  = NW - HW;       // high slice of numerator magnitude
  localparam int PMW  = DW + NW;       // offset product magnitude width
  localparam int QB   = DW;            // quotient bits before clamping
  localparam int SW   = QB + 3;        // width of start plus offset

  typedef logic [CW-1:0] coord_t;

  typedef struct packed {
    coord_t        start_x;
    coord_t        start_y;
    coord_t        start_z;
    coord_t        end_x;
    coord_t        end_y;
    coord_t        end_z;
    coord_t        centre_x;
    coord_t        centre_y;
    coord_t        centre_z;
    logic [CW-2:0] radius;
  } ssi_in_t;

  typedef struct packed {
    logic   hit_valid;
    coord_t hit_x;
    coord_t hit_y;
    coord_t hit_z;
    logic   degenerate;
  } ssi_out_t;

  // per item data that rides along the pipeline
  typedef struct packed {
    logic [2:0][CW-1:0] start;
    logic [2:0][DW-1:0] dmag;
    logic [2:0]         dneg;
    logic [PW-1:0]      a;
    logic [PW-1:0]      b;
    logic               deg;
    logic               miss;
  } ssi_side_t;

endpackage
`default_nettype wire

// ===== src/ssi_if.sv =====
// valid/ready channel interfaces for queries and results
`default_nettype none
interface ssi_in_if;
  import ssi_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] start_x;
  logic signed [CW-1:0] start_y;
  logic signed [CW-1:0] start_z;
  logic signed [CW-1:0] end_x;
  logic signed [CW-1:0] end_y;
  logic signed [CW-1:0] end_z;
  logic signed [CW-1:0] centre_x;
  logic signed [CW-1:0] centre_y;
  logic signed [CW-1:0] centre_z;
  logic [CW-2:0]        radius;

  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  centre_x, centre_y, centre_z, radius, input ready);
  modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                centre_x, centre_y, centre_z, radius, output ready);
endinterface

interface ssi_out_if;
  import ssi_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 hit_valid;
  logic signed [CW-1:0] hit_x;
  logic signed [CW-1:0] hit_y;
  logic signed [CW-1:0] hit_z;
  logic                 degenerate;

  modport source (output valid, hit_valid, hit_x, hit_y, hit_z, degenerate, input ready);
  modport sink (input valid, hit_valid, hit_x, hit_y, hit_z, degenerate, output ready);
endinterface
`default_nettype wire

// ===== src/segment_sphere_intersection.sv =====
// throughput: one transaction per cycle unless the output stalls; the square root
// (one bit per stage) and the 33 stage divider set the depth, not the rate
// a result held on the output with ready low freezes every stage at once
// reset (synchronous, active low) clears all stage valid bits; no data is reset
`default_nettype none
module segment_sphere_intersection (
  input  logic       clk,
  input  logic       rst_n,
  ssi_in_if.sink     in_ch,
  ssi_out_if.source  out_ch
);
  import ssi_pkg::*;

  logic      en;
  ssi_in_t   in_d;
  logic      q_vld, s_vld, d_vld;
  logic [QW-1:0] q_disc;
  ssi_side_t q_side, s_side;
  logic [RW-1:0] s_root;
  ssi_out_t  d_out;

  // the pipeline moves whenever the output slot is free or being drained
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  always_comb begin
    in_d.start_x  = in_ch.start_x;
    in_d.start_y  = in_ch.start_y;
    in_d.start_z  = in_ch.start_z;
    in_d.end_x    = in_ch.end_x;
    in_d.end_y    = in_ch.end_y;
    in_d.end_z    = in_ch.end_z;
    in_d.centre_x = in_ch.centre_x;
    in_d.centre_y = in_ch.centre_y;
    in_d.centre_z = in_ch.centre_z;
    in_d.radius   = in_ch.radius;
  end

  ssi_quad u_quad (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_ch.valid),
    .in_data  (in_d),
    .out_vld  (q_vld),
    .out_disc (q_disc),
    .out_side (q_side)
  );

  ssi_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (q_vld),
    .in_val   (q_disc),
    .in_side  (q_side),
    .out_vld  (s_vld),
    .out_root (s_root),
    .out_side (s_side)
  );

  ssi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s_vld),
    .in_root  (s_root),
    .in_side  (s_side),
    .out_vld  (d_vld),
    .out_data (d_out)
  );

  assign out_ch.valid      = d_vld;
  assign out_ch.hit_valid  = d_out.hit_valid;
  assign out_ch.hit_x      = d_out.hit_x;
  assign out_ch.hit_y      = d_out.hit_y;
  assign out_ch.hit_z      = d_out.hit_z;
  assign out_ch.degenerate = d_out.degenerate;

`ifndef SYNTHESIS
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while output stalled");

  a_hit_not_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.hit_valid && out_ch.degenerate))
    else $error("hit reported on a zero length segment");

  a_miss_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.hit_valid) |->
      (out_ch.hit_x == '0 && out_ch.hit_y == '0 && out_ch.hit_z == '0))
    else $error("nonzero point on a miss");
`endif

endmodule
`default_nettype wire

// ===== src/ssi_quad.sv =====
// quadratic coefficients and discriminant, seven register stages
`default_nettype none
module ssi_quad (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_vld,
  input  ssi_pkg::ssi_in_t        in_data,
  output logic                    out_vld,
  output logic [ssi_pkg::QW-1:0]  out_disc,
  output ssi_pkg::ssi_side_t      out_side
);
  import ssi_pkg::*;

  logic [6:0] vld_r;

  // stage 1: differences
  logic [2:0][CW-1:0]   st_w, en_w, ce_w;
  logic signed [DW-1:0] d_nxt [3];
  logic signed [DW-1:0] v_nxt [3];
  logic signed [DW-1:0] d1_r [3];
  logic signed [DW-1:0] v1_r [3];
  logic [CW-2:0]        rad1_r;
  logic [2:0][CW-1:0]   st1_r;

  // stage 2: products
  logic signed [2*DW-1:0] dd_nxt [3];
  logic signed [2*DW-1:0] dv_nxt [3];
  logic signed [2*DW-1:0] vv_nxt [3];
  logic signed [2*DW-1:0] dd2_r [3];
  logic signed [2*DW-1:0] dv2_r [3];
  logic signed [2*DW-1:0] vv2_r [3];
  logic [2*CW-3:0]        rr2_r;
  ssi_side_t              side2_nxt, side2_r;

  // stage 3: sums
  logic signed [PW-1:0] a3_nxt, b3_nxt, c3_nxt;
  logic signed [PW-1:0] a3_r, b3_r, c3_r;
  ssi_side_t            side3_r;

  // stage 4: magnitudes
  logic [PW-1:0] bfull, cfull;
  logic [MW-1:0] bmag4_r, cmag4_r;
  logic          cneg4_r;
  ssi_side_t     side4_nxt, side4_r;

  // stage 5: partial products
  logic [LW-1:0]   alo, blo, clo;
  logic [UW-1:0]   ahi, bhi, chi;
  logic [2*LW-1:0] bbll5_r, acll5_r;
  logic [LW+UW-1:0] bblh5_r, aclh5_r, achl5_r;
  logic [2*UW-1:0] bbhh5_r, achh5_r;
  logic            cneg5_r;
  ssi_side_t       side5_r;

  // stage 6: full products
  logic [QW-1:0] b2_6r, ac6_r;
  logic          cneg6_r;
  ssi_side_t     side6_r;

  // stage 7: discriminant
  logic [QW-1:0] disc_w;
  logic [QW-1:0] disc7_r;
  ssi_side_t     side7_nxt, side7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:0], in_vld};
    end
  end

  always_comb begin
    st_w = {in_data.start_z, in_data.start_y, in_data.start_x};
    en_w = {in_data.end_z, in_data.end_y, in_data.end_x};
    ce_w = {in_data.centre_z, in_data.centre_y, in_data.centre_x};
    for (int k = 0; k < 3; k++) begin
      d_nxt[k] = $signed({en_w[k][CW-1], en_w[k]}) - $signed({st_w[k][CW-1], st_w[k]});
      v_nxt[k] = $signed({st_w[k][CW-1], st_w[k]}) - $signed({ce_w[k][CW-1], ce_w[k]});
    end
  end

  always_comb begin
    side2_nxt = '0;
    side2_nxt.start = st1_r;
    for (int k = 0; k < 3; k++) begin
      dd_nxt[k] = d1_r[k] * d1_r[k];
      dv_nxt[k] = d1_r[k] * v1_r[k];
      vv_nxt[k] = v1_r[k] * v1_r[k];
      side2_nxt.dneg[k] = d1_r[k][DW-1];
      if (d1_r[k][DW-1]) begin
        side2_nxt.dmag[k] = -d1_r[k];
      end else begin
        side2_nxt.dmag[k] = d1_r[k];
      end
    end
  end

  always_comb begin
    a3_nxt = PW'(dd2_r[0]) + PW'(dd2_r[1]) + PW'(dd2_r[2]);
    b3_nxt = PW'(dv2_r[0]) + PW'(dv2_r[1]) + PW'(dv2_r[2]);
    c3_nxt = PW'(vv2_r[0]) + PW'(vv2_r[1]) + PW'(vv2_r[2]) - $signed({2'b00, rr2_r});
  end

  always_comb begin
    bfull = b3_r[PW-1] ? -b3_r : b3_r;
    cfull = c3_r[PW-1] ? -c3_r : c3_r;
    side4_nxt      = side3_r;
    side4_nxt.a    = a3_r;
    side4_nxt.b    = b3_r;
    side4_nxt.deg  = (a3_r == '0);
  end

  always_comb begin
    alo = side4_r.a[LW-1:0];
    ahi = side4_r.a[MW-1:LW];
    blo = bmag4_r[LW-1:0];
    bhi = bmag4_r[MW-1:LW];
    clo = cmag4_r[LW-1:0];
    chi = cmag4_r[MW-1:LW];
  end

  always_comb begin
    // c negative means a*c subtracts a negative amount
    if (cneg6_r) begin
      disc_w = b2_6r + ac6_r;
    end else begin
      disc_w = b2_6r - ac6_r;
    end
    side7_nxt      = side6_r;
    side7_nxt.miss = disc_w[QW-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        d1_r[k]  <= d_nxt[k];
        v1_r[k]  <= v_nxt[k];
        dd2_r[k] <= dd_nxt[k];
        dv2_r[k] <= dv_nxt[k];
        vv2_r[k] <= vv_nxt[k];
      end
      rad1_r  <= in_data.radius;
      st1_r   <= st_w;
      rr2_r   <= rad1_r * rad1_r;
      side2_r <= side2_nxt;

      a3_r    <= a3_nxt;
      b3_r    <= b3_nxt;
      c3_r    <= c3_nxt;
      side3_r <= side2_r;

      bmag4_r <= bfull[MW-1:0];
      cmag4_r <= cfull[MW-1:0];
      cneg4_r <= c3_r[PW-1];
      side4_r <= side4_nxt;

      bbll5_r <= blo * blo;
      bblh5_r <= blo * bhi;
      bbhh5_r <= bhi * bhi;
      acll5_r <= alo * clo;
      aclh5_r <= alo * chi;
      achl5_r <= ahi * clo;
      achh5_r <= ahi * chi;
      cneg5_r <= cneg4_r;
      side5_r <= side4_r;

      b2_6r   <= (QW'(bbhh5_r) << (2 * LW)) + (QW'(bblh5_r) << (LW + 1)) + QW'(bbll5_r);
      ac6_r   <= (QW'(achh5_r) << (2 * LW)) + ((QW'(aclh5_r) + QW'(achl5_r)) << LW)
                 + QW'(acll5_r);
      cneg6_r <= cneg5_r;
      side6_r <= side5_r;

      disc7_r <= disc_w[QW-1] ? '0 : disc_w;
      side7_r <= side7_nxt;
    end
  end

  assign out_vld  = vld_r[6];
  assign out_disc = disc7_r;
  assign out_side = side7_r;

endmodule
`default_nettype wire

// ===== src/ssi_sqrt.sv =====
// integer square root, one result bit per register stage
`default_nettype none
module ssi_sqrt (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_vld,
  input  logic [ssi_pkg::QW-1:0]  in_val,
  input  ssi_pkg::ssi_side_t      in_side,
  output logic                    out_vld,
  output logic [ssi_pkg::RW-1:0]  out_root,
  output ssi_pkg::ssi_side_t      out_side
);
  import ssi_pkg::*;

  logic [RW-1:0] vld_r;
  logic [RW:0]   rem_r  [RW];
  logic [RW-1:0] root_r [RW];
  logic [QW-1:0] rest_r [RW];
  ssi_side_t     side_r [RW];

  logic [RW:0]   rem_nxt  [RW];
  logic [RW-1:0] root_nxt [RW];
  logic [QW-1:0] rest_nxt [RW];
  ssi_side_t     side_nxt [RW];

  always_comb begin
    logic [RW:0]   rem_p;
    logic [RW-1:0] root_p;
    logic [QW-1:0] rest_p;
    logic [RW+1:0] cur, trial, diff;
    for (int i = 0; i < RW; i++) begin
      if (i == 0) begin
        rem_p       = '0;
        root_p      = '0;
        rest_p      = in_val;
        side_nxt[i] = in_side;
      end else begin
        rem_p       = rem_r[i-1];
        root_p      = root_r[i-1];
        rest_p      = rest_r[i-1];
        side_nxt[i] = side_r[i-1];
      end
      // bring down two bits, try (4*root+1)
      cur   = {rem_p[RW-1:0], rest_p[QW-1 -: 2]};
      trial = {root_p, 2'b01};
      diff  = cur - trial;
      if (cur >= trial) begin
        rem_nxt[i]  = diff[RW:0];
        root_nxt[i] = {root_p[RW-2:0], 1'b1};
      end else begin
        rem_nxt[i]  = cur[RW:0];
        root_nxt[i] = {root_p[RW-2:0], 1'b0};
      end
      rest_nxt[i] = rest_p << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[RW-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < RW; i++) begin
        rem_r[i]  <= rem_nxt[i];
        root_r[i] <= root_nxt[i];
        rest_r[i] <= rest_nxt[i];
        side_r[i] <= side_nxt[i];
      end
    end
  end

  assign out_vld  = vld_r[RW-1];
  assign out_root = root_r[RW-1];
  assign out_side = side_r[RW-1];

endmodule
`default_nettype wire

// ===== src/ssi_div.sv =====
// root selection, offset products, pipelined division and saturation
`default_nettype none
module ssi_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_vld,
  input  logic [ssi_pkg::RW-1:0]  in_root,
  input  ssi_pkg::ssi_side_t      in_side,
  output logic                    out_vld,
  output ssi_pkg::ssi_out_t       out_data
);
  import ssi_pkg::*;

  typedef struct packed {
    logic [2:0][CW-1:0] start;
    logic [PW-1:0]      a;
    logic               hit;
    logic               deg;
    logic [2:0]         pneg;
    logic [2:0]         ovf;
  } ssi_dctl_t;

  logic [5:0]    vx_r;
  logic [QB-1:0] vd_r;
  logic [1:0]    vf_r;

  // stage 1: both candidate numerators
  logic signed [NW-1:0] rt_w, bs_w;
  logic signed [NW-1:0] n1_1r, n2_1r;
  ssi_side_t            side1_r;

  // stage 2: selection
  logic signed [NW-1:0] num2_r;
  logic                 hit2_r;
  ssi_side_t            side2_r;

  // stage 3: magnitude
  logic [NW-1:0] nfull;
  logic [NW-1:0] nmag3_r;
  logic          nneg3_r;
  logic          hit3_r;
  ssi_side_t     side3_r;

  // stage 4: partial products per lane
  logic [DW+HW-1:0]  plo4_r [3];
  logic [DW+NHW-1:0] phi4_r [3];
  logic [2:0]        pneg4_r;
  logic              hit4_r;
  ssi_side_t         side4_r;

  // stage 5: product magnitude
  logic [PMW-1:0] pm5_r [3];
  logic [2:0]     pneg5_r;
  logic           hit5_r;
  ssi_side_t      side5_r;

  // stage 6: quotient overflow check
  logic [PMW-1:0] pm6_r [3];
  ssi_dctl_t      dc6_nxt, dc6_r;

  // division stages
  logic [PW-1:0] rem_r [QB][3];
  logic [QB-1:0] q_r   [QB][3];
  logic [QB-1:0] low_r [QB][3];
  ssi_dctl_t     dc_r  [QB];
  logic [PW-1:0] rem_nxt [QB][3];
  logic [QB-1:0] q_nxt   [QB][3];
  logic [QB-1:0] low_nxt [QB][3];

  // final stages
  logic signed [QB+1:0] qs_nxt [3];
  logic signed [QB+1:0] qs_f1r [3];
  ssi_dctl_t            dcf1_r;
  ssi_out_t             out_nxt, out_r;

  assign rt_w = {1'b0, in_root};
  assign bs_w = {in_side.b[PW-1], in_side.b};
  assign nfull = num2_r[NW-1] ? -num2_r : num2_r;

  always_comb begin
    dc6_nxt       = '0;
    dc6_nxt.start = side5_r.start;
    dc6_nxt.a     = side5_r.a;
    dc6_nxt.hit   = hit5_r;
    dc6_nxt.deg   = side5_r.deg;
    dc6_nxt.pneg  = pneg5_r;
    for (int k = 0; k < 3; k++) begin
      // quotient would reach 2^QB, far outside the coordinate range
      dc6_nxt.ovf[k] = pm5_r[k][PMW-1:QB] >= {1'b0, side5_r.a};
    end
  end

  always_comb begin
    logic [PW-1:0] rem_p;
    logic [QB-1:0] q_p, low_p;
    logic [PW:0]   cur, dif;
    for (int i = 0; i < QB; i++) begin
      for (int k = 0; k < 3; k++) begin
        if (i == 0) begin
          rem_p = pm6_r[k][QB +: PW];
          q_p   = '0;
          low_p = pm6_r[k][QB-1:0];
          cur   = {rem_p, low_p[QB-1]};
          dif   = cur - {1'b0, dc6_r.a};
          if (cur >= {1'b0, dc6_r.a}) begin
            rem_nxt[i][k] = dif[PW-1:0];
            q_nxt[i][k]   = {q_p[QB-2:0], 1'b1};
          end else begin
            rem_nxt[i][k] = cur[PW-1:0];
            q_nxt[i][k]   = {q_p[QB-2:0], 1'b0};
          end
        end else begin
          rem_p = rem_r[i-1][k];
          q_p   = q_r[i-1][k];
          low_p = low_r[i-1][k];
          cur   = {rem_p, low_p[QB-1]};
          dif   = cur - {1'b0, dc_r[i-1].a};
          if (cur >= {1'b0, dc_r[i-1].a}) begin
            rem_nxt[i][k] = dif[PW-1:0];
            q_nxt[i][k]   = {q_p[QB-2:0], 1'b1};
          end else begin
            rem_nxt[i][k] = cur[PW-1:0];
            q_nxt[i][k]   = {q_p[QB-2:0], 1'b0};
          end
        end
        low_nxt[i][k] = low_p << 1;
      end
    end
  end

  always_comb begin
    logic [QB:0]   qmag;
    logic [QB+1:0] qext;
    for (int k = 0; k < 3; k++) begin
      if (dc_r[QB-1].ovf[k]) begin
        qmag = {1'b1, {QB{1'b0}}};
      end else begin
        qmag = {1'b0, q_r[QB-1][k]};
      end
      qext = {1'b0, qmag};
      qs_nxt[k] = dc_r[QB-1].pneg[k] ? -$signed(qext) : $signed(qext);
    end
  end

  always_comb begin
    logic signed [SW-1:0] sum;
    logic [CW-1:0]        res [3];
    for (int k = 0; k < 3; k++) begin
      sum = $signed({{(SW-CW){dcf1_r.start[k][CW-1]}}, dcf1_r.start[k]})
            + $signed({qs_f1r[k][QB+1], qs_f1r[k]});
      if (!(&sum[SW-1:CW-1]) && (|sum[SW-1:CW-1])) begin
        res[k] = sum[SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end else begin
        res[k] = sum[CW-1:0];
      end
      if (!dcf1_r.hit) begin
        res[k] = '0;
      end
    end
    out_nxt.hit_valid  = dcf1_r.hit;
    out_nxt.hit_x      = res[0];
    out_nxt.hit_y      = res[1];
    out_nxt.hit_z      = res[2];
    out_nxt.degenerate = dcf1_r.deg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vx_r <= '0;
      vd_r <= '0;
      vf_r <= '0;
    end else if (en) begin
      vx_r <= {vx_r[4:0], in_vld};
      vd_r <= {vd_r[QB-2:0], vx_r[5]};
      vf_r <= {vf_r[0], vd_r[QB-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_1r   <= rt_w - bs_w;
      n2_1r   <= -bs_w - rt_w;
      side1_r <= in_side;

      hit2_r  <= !side1_r.deg && !side1_r.miss && !n1_1r[NW-1];
      num2_r  <= (n1_1r > $signed({1'b0, side1_r.a})) ? n2_1r : n1_1r;
      side2_r <= side1_r;

      nmag3_r <= nfull;
      nneg3_r <= num2_r[NW-1];
      hit3_r  <= hit2_r;
      side3_r <= side2_r;

      for (int k = 0; k < 3; k++) begin
        plo4_r[k]  <= side3_r.dmag[k] * nmag3_r[HW-1:0];
        phi4_r[k]  <= side3_r.dmag[k] * nmag3_r[NW-1:HW];
        pneg4_r[k] <= side3_r.dneg[k] ^ nneg3_r;
        pm5_r[k]   <= PMW'(plo4_r[k]) + (PMW'(phi4_r[k]) << HW);
        pm6_r[k]   <= pm5_r[k];
        qs_f1r[k]  <= qs_nxt[k];
      end
      hit4_r  <= hit3_r;
      side4_r <= side3_r;
      pneg5_r <= pneg4_r;
      hit5_r  <= hit4_r;
      side5_r <= side4_r;
      dc6_r   <= dc6_nxt;

      for (int i = 0; i < QB; i++) begin
        for (int k = 0; k < 3; k++) begin
          rem_r[i][k] <= rem_nxt[i][k];
          q_r[i][k]   <= q_nxt[i][k];
          low_r[i][k] <= low_nxt[i][k];
        end
        dc_r[i] <= (i == 0) ? dc6_r : dc_r[(i == 0) ? 0 : i-1];
      end

      dcf1_r <= dc_r[QB-1];
      out_r  <= out_nxt;
    end
  end

  assign out_vld  = vf_r[1];
  assign out_data = out_r;

endmodule
`default_nettype wire
